// ===== hw/rtl/kfsi_pkg.sv =====
// Shared types and constants for the keyframe store and interpolator.
`default_nettype none

package kfsi_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_EVAL   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOMATCH = 2'd3
    } status_t;

    // Config register indexes
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_TOLERANCE   = 1'b1;

    localparam logic [4:0]  POINT_COUNT_RESET = 5'd4;
    localparam logic [15:0] TOLERANCE_RESET   = 16'd66;

    // Fraction is Q0.16 plus one integer bit: 17 quotient bits
    localparam int DIV_STEPS = 17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_POST,
        S_SLOT,
        S_SH_RD,
        S_SH_WR,
        S_CLEAR,
        S_RM_RD,
        S_RM_WR,
        S_DIV,
        S_EV_RD,
        S_EV_MUL,
        S_EV_OUT,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/keyframe_store_interpolator.sv =====
// Keyframe table with sorted insert/remove and linear interpolation of curve points.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, req_type, key_time,          | input
//          | point_index, point_x, point_y                   |
//  out     | out_valid/out_ready, status, out_index, out_x,  | output
//          | out_y, last                                     |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | input
//
// One request is processed at a time. Table scan streams one key entry per
// cycle. Insert/remove shift key entries with a read and a write each
// through the key memory port; opening a keyframe writes point 0 and clears
// the other MAX_POINTS - 1 point entries. Evaluate: scan, restoring divider for
// the fraction between keyframes, then per reported point: read, multiply, add.
// Reset: rst_n async, clears control; memories are undefined until written.
// The output register lets the next transaction be accepted while a result
// still waits; the engine stalls only when it needs to emit into a full slot.
`default_nettype none

module keyframe_store_interpolator
    import kfsi_pkg::*;
#(
    parameter int MAX_KEYS   = 32,
    parameter int MAX_POINTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] key_time,
    input  wire logic [3:0]  point_index,
    input  wire logic [31:0] point_x,
    input  wire logic [31:0] point_y,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [3:0]       out_index,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic             last,
    // config channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int SW   = $clog2(MAX_KEYS);                      // slot / key index
    localparam int KCW  = $clog2(MAX_KEYS + 1);                  // key count
    localparam int PIW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PNW  = $clog2(MAX_POINTS + 1);
    localparam int PDEP = MAX_KEYS * MAX_POINTS;
    localparam int PAW  = $clog2(PDEP);
    localparam int KEW  = 32 + SW;                               // {time, slot}

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [4:0]          point_count_reg;
    logic [15:0]         tol_reg;
    logic [KCW-1:0]      key_count_reg;
    logic [MAX_KEYS-1:0] free_reg;
    logic [SW-1:0]       recent_reg;
    logic                chk_vld_reg;

    // captured request
    req_t         req_reg;
    logic [31:0]  time_reg;
    logic [3:0]   pidx_reg;
    logic [31:0]  px_reg;
    logic [31:0]  py_reg;
    status_t      resp_status_reg;

    // scan
    logic [KCW-1:0] scan_idx_reg;
    logic [KCW-1:0] chk_idx_reg;
    logic           hit_reg;
    logic [KCW-1:0] pos_reg;
    logic [31:0]    cur_time_reg;
    logic [SW-1:0]  cur_slot_reg;
    logic [31:0]    prev_time_reg;
    logic [SW-1:0]  prev_slot_reg;

    // edit / evaluate
    logic [SW-1:0]  new_slot_reg;
    logic [KCW-1:0] ins_idx_reg;
    logic [PIW-1:0] pt_idx_reg;
    logic [SW-1:0]  s1_reg;
    logic [SW-1:0]  s2_reg;
    logic [31:0]    den_reg;
    logic [32:0]    rem_reg;
    logic [16:0]    frac_reg;
    logic [4:0]     div_cnt_reg;
    logic [31:0]    a_x_reg;
    logic [31:0]    a_y_reg;
    logic [47:0]    prod_x_reg;
    logic [47:0]    prod_y_reg;

    // output register
    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [3:0]     out_index_reg;
    logic [31:0]    out_x_reg;
    logic [31:0]    out_y_reg;
    logic           last_reg;

    // memories
    logic [KEW-1:0] kt_mem [MAX_KEYS];
    logic [KEW-1:0] kt_q_reg;
    logic [63:0]    pt_mem [PDEP];
    logic [63:0]    pt_a_reg;
    logic [63:0]    pt_b_reg;

    // ---------------- combinational ----------------
    logic           kt_rd_en;
    logic [SW-1:0]  kt_rd_addr;
    logic           kt_wr_en;
    logic [SW-1:0]  kt_wr_addr;
    logic [KEW-1:0] kt_wr_data;
    logic           pt_rd_en;
    logic [PAW-1:0] pt_addr_a;
    logic [PAW-1:0] pt_addr_b;
    logic           pt_wr_en;
    logic [PAW-1:0] pt_wr_addr;
    logic [63:0]    pt_wr_data;

    logic           emit;
    status_t        emit_status;
    logic [3:0]     emit_index;
    logic [31:0]    emit_x;
    logic [31:0]    emit_y;
    logic           emit_last;
    logic           out_load;

    logic [31:0]    kt_time;
    logic [SW-1:0]  kt_slot;
    logic [31:0]    time_diff;
    logic           scan_issue;
    logic           scan_hit;
    logic [KCW-1:0] ins_dec;
    logic [KCW-1:0] ins_inc;
    logic           rm_done;
    logic           pi_bad;
    logic           table_full;
    logic           table_empty;
    logic           interp;
    logic [PNW-1:0] n_eff;
    logic           ev_last;
    logic           div_ge;
    logic [32:0]    rem_sub;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [50:0] prod_x_full;
    logic signed [50:0] prod_y_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_index = out_index_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign last      = last_reg;

    assign out_load = emit && (!out_valid_reg || out_ready);

    assign kt_time     = kt_q_reg[KEW-1:SW];
    assign kt_slot     = kt_q_reg[SW-1:0];
    assign time_diff   = (kt_time > time_reg) ? (kt_time - time_reg) : (time_reg - kt_time);
    assign scan_issue  = (scan_idx_reg < key_count_reg);
    // remove: first entry within tolerance; add/eval: first entry not before the time
    assign scan_hit    = (req_reg == REQ_REMOVE) ? (time_diff < {16'd0, tol_reg})
                                                 : (kt_time >= time_reg);
    assign ins_dec     = ins_idx_reg - KCW'(1);
    assign ins_inc     = ins_idx_reg + KCW'(1);
    assign rm_done     = (ins_inc >= key_count_reg);
    assign pi_bad      = ({28'd0, pidx_reg} >= 32'(MAX_POINTS));
    assign table_full  = (32'(key_count_reg) >= 32'(MAX_KEYS));
    assign table_empty = (key_count_reg == '0);
    assign interp      = hit_reg && (pos_reg != '0);

    // point_count of 0 acts as 1, above MAX_POINTS acts as MAX_POINTS
    always_comb
    begin
        if (point_count_reg == 5'd0)
            n_eff = PNW'(1);
        else if ({27'd0, point_count_reg} > 32'(MAX_POINTS))
            n_eff = PNW'(MAX_POINTS);
        else
            n_eff = PNW'(point_count_reg);
    end

    assign ev_last = ((PNW'(pt_idx_reg) + PNW'(1)) == n_eff);

    // restoring divider step
    assign div_ge  = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // lerp: p1 + floor((p2 - p1) * f / 2^16), low 32 bits of the shift
    assign dx = $signed({pt_b_reg[63], pt_b_reg[63:32]}) - $signed({pt_a_reg[63], pt_a_reg[63:32]});
    assign dy = $signed({pt_b_reg[31], pt_b_reg[31:0]}) - $signed({pt_a_reg[31], pt_a_reg[31:0]});
    assign prod_x_full = dx * $signed({1'b0, frac_reg});
    assign prod_y_full = dy * $signed({1'b0, frac_reg});

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (req_reg)
                    REQ_ADD:
                        if (!pi_bad && pidx_reg == 4'd0 && !table_full)
                            state_next = S_SCAN;
                        else
                            state_next = S_RESP;
                    REQ_REMOVE, REQ_EVAL:
                        state_next = table_empty ? S_RESP : S_SCAN;
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_SCAN:
                if ((chk_vld_reg && scan_hit) || (!chk_vld_reg && !scan_issue))
                    state_next = S_POST;
            S_POST:
            begin
                unique case (req_reg)
                    REQ_ADD:    state_next = S_SLOT;
                    REQ_REMOVE: state_next = hit_reg ? S_RM_RD : S_RESP;
                    default:    state_next = interp ? S_DIV : S_EV_RD;
                endcase
            end
            S_SLOT:
                if (free_reg[new_slot_reg])
                    state_next = S_SH_RD;
            S_SH_RD:
                state_next = (ins_idx_reg == pos_reg) ? S_CLEAR : S_SH_WR;
            S_SH_WR:
                state_next = S_SH_RD;
            S_CLEAR:
                if (pt_idx_reg == PIW'(MAX_POINTS - 1))
                    state_next = S_RESP;
            S_RM_RD:
                state_next = rm_done ? S_RESP : S_RM_WR;
            S_RM_WR:
                state_next = S_RM_RD;
            S_DIV:
                if (div_cnt_reg == 5'd1)
                    state_next = S_EV_RD;
            S_EV_RD:
                state_next = S_EV_MUL;
            S_EV_MUL:
                state_next = S_EV_OUT;
            S_EV_OUT:
                if (out_load)
                    state_next = ev_last ? S_IDLE : S_EV_RD;
            S_RESP:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // ---------------- memory controls and result ----------------
    always_comb
    begin
        kt_rd_en    = 1'b0;
        kt_rd_addr  = '0;
        kt_wr_en    = 1'b0;
        kt_wr_addr  = '0;
        kt_wr_data  = kt_q_reg;
        pt_rd_en    = 1'b0;
        pt_addr_a   = PAW'(s1_reg) * PAW'(MAX_POINTS) + PAW'(pt_idx_reg);
        pt_addr_b   = PAW'(s2_reg) * PAW'(MAX_POINTS) + PAW'(pt_idx_reg);
        pt_wr_en    = 1'b0;
        pt_wr_addr  = PAW'(new_slot_reg) * PAW'(MAX_POINTS) + PAW'(pt_idx_reg);
        pt_wr_data  = 64'd0;
        emit        = 1'b0;
        emit_status = resp_status_reg;
        emit_index  = 4'd0;
        emit_x      = 32'd0;
        emit_y      = 32'd0;
        emit_last   = 1'b1;
        unique case (state_reg)
            S_DISPATCH:
                // later point of the most recent keyframe
                if (req_reg == REQ_ADD && !pi_bad && pidx_reg != 4'd0 && !table_empty
                    && !free_reg[recent_reg])
                begin
                    pt_wr_en   = 1'b1;
                    pt_wr_addr = PAW'(recent_reg) * PAW'(MAX_POINTS) + PAW'(pidx_reg);
                    pt_wr_data = {px_reg, py_reg};
                end
            S_SCAN:
            begin
                kt_rd_en   = scan_issue;
                kt_rd_addr = scan_idx_reg[SW-1:0];
            end
            S_SH_RD:
                if (ins_idx_reg == pos_reg)
                begin
                    kt_wr_en   = 1'b1;
                    kt_wr_addr = pos_reg[SW-1:0];
                    kt_wr_data = {time_reg, new_slot_reg};
                end
                else
                begin
                    kt_rd_en   = 1'b1;
                    kt_rd_addr = ins_dec[SW-1:0];
                end
            S_SH_WR:
            begin
                kt_wr_en   = 1'b1;
                kt_wr_addr = ins_idx_reg[SW-1:0];
            end
            S_CLEAR:
            begin
                pt_wr_en   = 1'b1;
                pt_wr_data = (pt_idx_reg == '0) ? {px_reg, py_reg} : 64'd0;
            end
            S_RM_RD:
                if (!rm_done)
                begin
                    kt_rd_en   = 1'b1;
                    kt_rd_addr = ins_inc[SW-1:0];
                end
            S_RM_WR:
            begin
                kt_wr_en   = 1'b1;
                kt_wr_addr = ins_idx_reg[SW-1:0];
            end
            S_EV_RD:
                pt_rd_en = 1'b1;
            S_EV_OUT:
            begin
                emit        = 1'b1;
                emit_status = STAT_OK;
                emit_index  = 4'(pt_idx_reg);
                emit_x      = a_x_reg + prod_x_reg[47:16];
                emit_y      = a_y_reg + prod_y_reg[47:16];
                emit_last   = ev_last;
            end
            S_RESP:
                emit = 1'b1;
            default:
            begin
            end
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (kt_wr_en)
            kt_mem[kt_wr_addr] <= kt_wr_data;
        if (kt_rd_en)
            kt_q_reg <= kt_mem[kt_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pt_wr_en)
            pt_mem[pt_wr_addr] <= pt_wr_data;
        if (pt_rd_en)
        begin
            pt_a_reg <= pt_mem[pt_addr_a];
            pt_b_reg <= pt_mem[pt_addr_b];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= POINT_COUNT_RESET;
            tol_reg         <= TOLERANCE_RESET;
            key_count_reg   <= '0;
            free_reg        <= '1;
            recent_reg      <= '0;
            chk_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                if (cfg_index == CFG_POINT_COUNT)
                    point_count_reg <= cfg_data[4:0];
                else
                    tol_reg <= cfg_data;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_DISPATCH:
                    chk_vld_reg <= 1'b0;
                S_SCAN:
                    chk_vld_reg <= scan_issue;
                S_SH_RD:
                    if (ins_idx_reg == pos_reg)
                    begin
                        key_count_reg          <= key_count_reg + KCW'(1);
                        free_reg[new_slot_reg] <= 1'b0;
                        recent_reg             <= new_slot_reg;
                    end
                S_RM_RD:
                    if (rm_done)
                    begin
                        key_count_reg          <= key_count_reg - KCW'(1);
                        free_reg[cur_slot_reg] <= 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg    <= emit_status;
            out_index_reg <= emit_index;
            out_x_reg     <= emit_x;
            out_y_reg     <= emit_y;
            last_reg      <= emit_last;
        end

        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    req_reg  <= req_t'(req_type);
                    time_reg <= key_time;
                    pidx_reg <= point_index;
                    px_reg   <= point_x;
                    py_reg   <= point_y;
                end
            S_DISPATCH:
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
                new_slot_reg <= '0;
                case (req_reg)
                    REQ_ADD:
                        if (pi_bad)
                            resp_status_reg <= STAT_NOMATCH;
                        else if (pidx_reg == 4'd0)
                            resp_status_reg <= table_full ? STAT_FULL : STAT_OK;
                        else if (table_empty)
                            resp_status_reg <= STAT_EMPTY;
                        else if (free_reg[recent_reg])
                            resp_status_reg <= STAT_NOMATCH;
                        else
                            resp_status_reg <= STAT_OK;
                    REQ_REMOVE, REQ_EVAL:
                        resp_status_reg <= table_empty ? STAT_EMPTY : STAT_OK;
                    default:
                        resp_status_reg <= STAT_OK;
                endcase
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + KCW'(1);
                    chk_idx_reg  <= scan_idx_reg;
                end
                if (chk_vld_reg)
                begin
                    if (scan_hit)
                    begin
                        hit_reg      <= 1'b1;
                        pos_reg      <= chk_idx_reg;
                        cur_time_reg <= kt_time;
                        cur_slot_reg <= kt_slot;
                    end
                    else
                    begin
                        prev_time_reg <= kt_time;
                        prev_slot_reg <= kt_slot;
                    end
                end
                else if (!scan_issue)
                    pos_reg <= key_count_reg;   // nothing matched: past the end
            end
            S_POST:
            begin
                pt_idx_reg  <= '0;
                frac_reg    <= '0;
                div_cnt_reg <= 5'(DIV_STEPS);
                case (req_reg)
                    REQ_ADD:
                        ins_idx_reg <= key_count_reg;
                    REQ_REMOVE:
                    begin
                        ins_idx_reg <= pos_reg;
                        if (!hit_reg)
                            resp_status_reg <= STAT_NOMATCH;
                    end
                    default:
                        if (!hit_reg)
                        begin
                            // after the last keyframe
                            s1_reg <= prev_slot_reg;
                            s2_reg <= prev_slot_reg;
                        end
                        else if (pos_reg == '0)
                        begin
                            // at or before the first keyframe
                            s1_reg <= cur_slot_reg;
                            s2_reg <= cur_slot_reg;
                        end
                        else
                        begin
                            s1_reg  <= prev_slot_reg;
                            s2_reg  <= cur_slot_reg;
                            rem_reg <= {1'b0, time_reg - prev_time_reg};
                            den_reg <= cur_time_reg - prev_time_reg;
                        end
                endcase
            end
            S_SLOT:
                if (!free_reg[new_slot_reg])
                    new_slot_reg <= new_slot_reg + SW'(1);
            S_SH_WR:
                ins_idx_reg <= ins_dec;
            S_CLEAR:
                pt_idx_reg <= pt_idx_reg + PIW'(1);
            S_RM_WR:
                ins_idx_reg <= ins_inc;
            S_DIV:
            begin
                frac_reg    <= {frac_reg[15:0], div_ge};
                rem_reg     <= {rem_sub[31:0], 1'b0};
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            S_EV_MUL:
            begin
                a_x_reg    <= pt_a_reg[63:32];
                a_y_reg    <= pt_a_reg[31:0];
                prod_x_reg <= prod_x_full[47:0];
                prod_y_reg <= prod_y_full[47:0];
            end
            S_EV_OUT:
                if (out_load)
                    pt_idx_reg <= pt_idx_reg + PIW'(1);
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // every slot is either free or owned by exactly one keyframe
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(free_reg)) + 32'(key_count_reg) == 32'(MAX_KEYS))
        else $error("free slot count and key count disagree");

    // an accepted transaction always moves the engine to dispatch
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted transaction not dispatched");

    // the interpolation fraction never exceeds one
    a_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == 5'd1) |=> (frac_reg <= 17'h10000))
        else $error("interpolation fraction above one");

    // the engine only emits when the output slot can take it
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_EV_OUT))
        else $error("evaluate result dropped");
`endif

endmodule

`default_nettype wire
